>>> rtl/asx_pkg.sv
package asx_pkg;

   // instruction classes
   localparam logic [1:0] OP_DP  = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_LS  = 2'd2;
   localparam logic [1:0] OP_BR  = 2'd3;

   // condition codes
   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;
   localparam logic [3:0] COND_AL = 4'd14;

   // data-processing opcodes
   localparam logic [3:0] ALU_AND = 4'd0;
   localparam logic [3:0] ALU_EOR = 4'd1;
   localparam logic [3:0] ALU_SUB = 4'd2;
   localparam logic [3:0] ALU_RSB = 4'd3;
   localparam logic [3:0] ALU_ADD = 4'd4;
   localparam logic [3:0] ALU_TST = 4'd8;
   localparam logic [3:0] ALU_TEQ = 4'd9;
   localparam logic [3:0] ALU_CMP = 4'd10;
   localparam logic [3:0] ALU_ORR = 4'd12;
   localparam logic [3:0] ALU_MOV = 4'd13;

   // shift kinds
   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   // result status
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_SKIP    = 2'd1;
   localparam logic [1:0] STAT_ILLEGAL = 2'd2;
   localparam logic [1:0] STAT_BOUNDS  = 2'd3;

   // mode bits
   localparam int MB_IMM  = 0;
   localparam int MB_PRE  = 1;
   localparam int MB_UP   = 2;
   localparam int MB_LOAD = 3;

   // flag positions in NZCV
   localparam int FL_N = 3;
   localparam int FL_Z = 2;
   localparam int FL_C = 1;
   localparam int FL_V = 0;

   localparam logic [3:0] PC_INDEX = 4'd15;

   localparam logic CSR_GPIO_BASE  = 1'b0;
   localparam logic CSR_GPIO_LIMIT = 1'b1;

   localparam logic [31:0] GPIO_BASE_RESET  = 32'h2020_0000;
   localparam logic [31:0] GPIO_LIMIT_RESET = 32'h2020_0030;

   typedef struct packed {
      logic        en;
      logic [3:0]  addr;
      logic [31:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic        we;
      logic [31:0] addr;
      logic [31:0] wdata;
   } mem_req_type;

endpackage

>>> rtl/asx_regfile.sv
module asx_regfile (
   input  logic              clock,
   input  logic              reset,
   input  logic [3:0]        rd_addr_a,
   input  logic [3:0]        rd_addr_b,
   output logic [31:0]       rd_data_a,
   output logic [31:0]       rd_data_b,
   input  asx_pkg::rf_wr_type wr
);

   logic [31:0] ram [16];
   logic [15:0] valid_ff;
   logic [31:0] a_raw_ff;
   logic [31:0] b_raw_ff;
   logic        a_vld_ff;
   logic        b_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ram[wr.addr] <= wr.data;
      end
      a_raw_ff <= ram[rd_addr_a];
      b_raw_ff <= ram[rd_addr_b];
      a_vld_ff <= valid_ff[rd_addr_a];
      b_vld_ff <= valid_ff[rd_addr_b];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data_a = a_vld_ff ? a_raw_ff : '0;
   assign rd_data_b = b_vld_ff ? b_raw_ff : '0;

endmodule

>>> rtl/asx_mem.sv
module asx_mem #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  asx_pkg::mem_req_type req,
   output logic [31:0]          rdata,
   output logic                 busy
);

   localparam int ROWS = (MEM_BYTES + 3) / 4;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [RW-1:0] clr_row_ff;
   logic          busy_ff;
   logic [1:0]    low_ff;
   logic [7:0]    bank_q [4];

   // four byte lanes, so an unaligned word touches one row per lane
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0]    ram [ROWS];
      logic [1:0]    k;
      logic [31:0]   sum;
      logic [RW-1:0] row;
      logic [7:0]    wbyte;
      logic [7:0]    rbyte_ff;

      assign k     = 2'(b) - req.addr[1:0];
      assign sum   = req.addr + {30'b0, k};
      assign row   = sum[RW+1:2];
      assign wbyte = 8'(req.wdata >> {k, 3'b000});

      always_ff @(posedge clock) begin
         if (busy_ff) begin
            ram[clr_row_ff] <= '0;
         end else if (req.we) begin
            ram[row] <= wbyte;
         end
         rbyte_ff <= ram[row];
      end

      assign bank_q[b] = rbyte_ff;
   end

   always_ff @(posedge clock) begin
      low_ff <= req.addr[1:0];
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rdata[8*k +: 8] = bank_q[2'(low_ff + 2'(k))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_row_ff <= '0;
      end else if (busy_ff) begin
         if (clr_row_ff == RW'(ROWS - 1)) begin
            busy_ff <= 1'b0;
         end
         clr_row_ff <= clr_row_ff + 1'b1;
      end
   end

   assign busy = busy_ff;

endmodule

>>> rtl/arm_subset_execute_stage.sv
// Executes one decoded instruction per transfer and returns one result per
// instruction. Each instruction steps through the states RD2, EXEC, ALU and
// DONE, with MEM between ALU and DONE for a load: the register file is read
// as two pairs through its two read ports, EXEC runs shifter and multiplier,
// ALU does the ALU and write-back, and MEM does the byte memory read. The next
// instruction is accepted the cycle after the previous one hands its result to
// the output register, so a result waiting on rsp_tready blocks new work only
// once the next instruction reaches DONE. After reset the byte memory is
// cleared, one 4-byte row per cycle, and req_tready stays low until it is done.
module arm_subset_execute_stage #(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cond, alu_op, mode_bits, dest_reg, base_reg, shift_reg, operand_reg,
   // shift_type, shift_count, immediate, zero pad
   input  logic [71:0] req_tdata,
   // op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // flags_out, result_value, zero pad
   output logic [39:0] rsp_tdata,
   // status, flush
   output logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD2,
      S_EXEC,
      S_ALU,
      S_MEM,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]  op_ff;
   logic [3:0]  cond_ff, alu_ff, mb_ff, rd_ff, rn_ff, rs_ff, rm_ff;
   logic [1:0]  st_ff;
   logic [4:0]  sc_ff;
   logic [31:0] imm_ff;

   logic [31:0] a_val_ff, m_val_ff;
   logic [31:0] op2_ff, off_ff, prod_ff, data_ff;
   logic        shc_ff;

   logic [3:0]  flags_ff;
   logic [31:0] gpio_base_ff, gpio_limit_ff;

   logic [31:0] addr_ff;
   logic        in_mem_ff, in_win_ff;

   logic [1:0]  pend_status_ff;
   logic        pend_flush_ff;
   logic [31:0] pend_res_ff;

   logic        rsp_tvalid_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_flush_ff;
   logic [3:0]  rsp_flags_ff;
   logic [31:0] rsp_result_ff;

   logic [3:0]  rf_addr_a, rf_addr_b;
   logic [31:0] rf_data_a, rf_data_b;
   asx_pkg::rf_wr_type   rf_wr;
   asx_pkg::mem_req_type mem_req;
   logic [31:0] mem_rdata;
   logic        mem_busy;

   logic        accept;

   function automatic logic [32:0] barrel(input logic [1:0] kind, input logic [31:0] amt,
                                          input logic [31:0] v);
      logic [31:0] a;
      logic [63:0] t;
      logic [32:0] r;
      a = (kind == asx_pkg::SH_ROR) ? {27'b0, amt[4:0]} : amt;
      r = {1'b0, v};
      t = '0;
      if (a != 32'd0) begin
         case (kind)
            asx_pkg::SH_LSL: begin
               t = {32'b0, v} << a[4:0];
               if (a < 32'd32)       r = {t[32], t[31:0]};
               else if (a == 32'd32) r = {v[0], 32'b0};
               else                  r = '0;
            end
            asx_pkg::SH_LSR: begin
               t = {v, 32'b0} >> a[4:0];
               if (a < 32'd32)       r = {t[31], t[63:32]};
               else if (a == 32'd32) r = {v[31], 32'b0};
               else                  r = '0;
            end
            asx_pkg::SH_ASR: begin
               t = 64'($signed({v, 32'b0}) >>> a[4:0]);
               if (a < 32'd32) r = {t[31], t[63:32]};
               else            r = {v[31], {32{v[31]}}};
            end
            default: begin
               t = {v, v} >> a[4:0];
               r = {t[31], t[31:0]};
            end
         endcase
      end
      return r;
   endfunction

   asx_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_a (rf_addr_a),
      .rd_addr_b (rf_addr_b),
      .rd_data_a (rf_data_a),
      .rd_data_b (rf_data_b),
      .wr        (rf_wr)
   );

   asx_mem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_mem (
      .clock (clock),
      .reset (reset),
      .req   (mem_req),
      .rdata (mem_rdata),
      .busy  (mem_busy)
   );

   assign req_tready = (state_ff == S_IDLE) && !mem_busy;
   assign accept     = req_tvalid && req_tready;

   // first read pair: base (or pc for a branch) and operand; second: shift and dest
   always_comb begin
      if (state_ff == S_IDLE) begin
         rf_addr_a = (req_tuser == asx_pkg::OP_BR) ? asx_pkg::PC_INDEX : req_tdata[19:16];
         rf_addr_b = req_tdata[27:24];
      end else begin
         rf_addr_a = rs_ff;
         rf_addr_b = rd_ff;
      end
   end

   // shifter, offset and multiplier stage
   logic [31:0] amount;
   logic [32:0] sh_reg, sh_imm;
   logic [31:0] off_raw;

   always_comb begin
      amount  = (rs_ff == 4'd0) ? {27'b0, sc_ff} : rf_data_a;
      sh_reg  = barrel(st_ff, amount, m_val_ff);
      sh_imm  = barrel(st_ff, {27'b0, sc_ff}, imm_ff);
      off_raw = mb_ff[asx_pkg::MB_IMM] ? sh_reg[31:0] : imm_ff;
   end

   // condition check and ALU
   logic        z_fl, nv_fl, cond_legal, cond_ok, go;
   logic [32:0] sub33, rsb33, add33;
   logic [31:0] dp_res;
   logic        dp_fc, dp_logical, dp_write, dp_legal;
   logic [31:0] mul_res, ls_sum, ls_addr, br_res;
   logic        in_mem, in_win;

   always_comb begin
      z_fl       = flags_ff[asx_pkg::FL_Z];
      nv_fl      = flags_ff[asx_pkg::FL_N] == flags_ff[asx_pkg::FL_V];
      cond_legal = 1'b1;
      case (cond_ff)
         asx_pkg::COND_EQ: cond_ok = z_fl;
         asx_pkg::COND_NE: cond_ok = !z_fl;
         asx_pkg::COND_GE: cond_ok = nv_fl;
         asx_pkg::COND_LT: cond_ok = !nv_fl;
         asx_pkg::COND_GT: cond_ok = !z_fl && nv_fl;
         asx_pkg::COND_LE: cond_ok = z_fl || !nv_fl;
         asx_pkg::COND_AL: cond_ok = 1'b1;
         default: begin
            cond_ok    = 1'b0;
            cond_legal = 1'b0;
         end
      endcase
      go = cond_legal && cond_ok;

      sub33 = {1'b0, a_val_ff} - {1'b0, op2_ff};
      rsb33 = {1'b0, op2_ff} - {1'b0, a_val_ff};
      add33 = {1'b0, a_val_ff} + {1'b0, op2_ff};

      dp_logical = 1'b0;
      dp_write   = 1'b1;
      dp_legal   = 1'b1;
      dp_fc      = 1'b0;
      dp_res     = '0;
      case (alu_ff)
         asx_pkg::ALU_AND, asx_pkg::ALU_TST: begin
            dp_res     = a_val_ff & op2_ff;
            dp_logical = 1'b1;
            dp_write   = alu_ff == asx_pkg::ALU_AND;
         end
         asx_pkg::ALU_EOR, asx_pkg::ALU_TEQ: begin
            dp_res     = a_val_ff ^ op2_ff;
            dp_logical = 1'b1;
            dp_write   = alu_ff == asx_pkg::ALU_EOR;
         end
         asx_pkg::ALU_SUB, asx_pkg::ALU_CMP: begin
            dp_res   = sub33[31:0];
            dp_fc    = !sub33[32];
            dp_write = alu_ff == asx_pkg::ALU_SUB;
         end
         asx_pkg::ALU_RSB: begin
            dp_res = rsb33[31:0];
            dp_fc  = !rsb33[32];
         end
         asx_pkg::ALU_ADD: begin
            dp_res = add33[31:0];
            dp_fc  = add33[32];
         end
         asx_pkg::ALU_ORR: begin
            dp_res     = a_val_ff | op2_ff;
            dp_logical = 1'b1;
         end
         asx_pkg::ALU_MOV: begin
            dp_res     = op2_ff;
            dp_logical = 1'b1;
         end
         default: begin
            dp_legal = 1'b0;
            dp_write = 1'b0;
         end
      endcase
      if (dp_logical) dp_fc = shc_ff;

      mul_res = prod_ff + (mb_ff[asx_pkg::MB_UP] ? a_val_ff : 32'd0);
      ls_sum  = a_val_ff + off_ff;
      ls_addr = mb_ff[asx_pkg::MB_PRE] ? ls_sum : a_val_ff;
      in_mem  = ({1'b0, ls_addr} + 33'd4) <= 33'(MEM_BYTES);
      in_win  = (ls_addr >= gpio_base_ff) && (ls_addr < gpio_limit_ff);
      br_res  = a_val_ff + imm_ff;
   end

   logic [31:0] load_val;
   assign load_val = in_mem_ff ? mem_rdata : (in_win_ff ? addr_ff : 32'd0);

   // register-file write and memory request
   always_comb begin
      rf_wr         = '0;
      mem_req.we    = 1'b0;
      mem_req.addr  = ls_addr;
      mem_req.wdata = data_ff;
      if (state_ff == S_ALU && go) begin
         case (op_ff)
            asx_pkg::OP_DP: begin
               rf_wr.en   = dp_legal && dp_write;
               rf_wr.addr = rd_ff;
               rf_wr.data = dp_res;
            end
            asx_pkg::OP_MUL: begin
               rf_wr.en   = 1'b1;
               rf_wr.addr = rd_ff;
               rf_wr.data = mul_res;
            end
            asx_pkg::OP_LS: begin
               // post-index write-back; a load to the same register lands later
               rf_wr.en   = !mb_ff[asx_pkg::MB_PRE];
               rf_wr.addr = rn_ff;
               rf_wr.data = ls_sum;
               mem_req.we = !mb_ff[asx_pkg::MB_LOAD] && in_mem;
            end
            default: begin
               rf_wr.en   = 1'b1;
               rf_wr.addr = asx_pkg::PC_INDEX;
               rf_wr.data = br_res;
            end
         endcase
      end else if (state_ff == S_MEM) begin
         rf_wr.en   = 1'b1;
         rf_wr.addr = rd_ff;
         rf_wr.data = load_val;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_RD2;
         S_RD2:  state_in = S_EXEC;
         S_EXEC: state_in = S_ALU;
         S_ALU: begin
            if (go && op_ff == asx_pkg::OP_LS && mb_ff[asx_pkg::MB_LOAD]) state_in = S_MEM;
            else                                                          state_in = S_DONE;
         end
         S_MEM:  state_in = S_DONE;
         S_DONE: if (!rsp_tvalid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         flags_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_tready) rsp_tvalid_ff <= 1'b0;
         case (state_ff)
            S_ALU: begin
               if (go && op_ff == asx_pkg::OP_DP && dp_legal && mb_ff[asx_pkg::MB_LOAD]) begin
                  flags_ff <= {dp_res[31], dp_res == 32'd0, dp_fc, flags_ff[asx_pkg::FL_V]};
               end else if (go && op_ff == asx_pkg::OP_MUL && mb_ff[asx_pkg::MB_LOAD]) begin
                  flags_ff <= {mul_res[31], mul_res == 32'd0, flags_ff[1:0]};
               end
            end
            S_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_status_ff <= pend_status_ff;
                  rsp_flush_ff  <= pend_flush_ff;
                  rsp_flags_ff  <= flags_ff;
                  rsp_result_ff <= pend_res_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpio_base_ff  <= asx_pkg::GPIO_BASE_RESET;
         gpio_limit_ff <= asx_pkg::GPIO_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            asx_pkg::CSR_GPIO_BASE:  gpio_base_ff  <= csr_wdata;
            asx_pkg::CSR_GPIO_LIMIT: gpio_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_tuser;
         cond_ff <= req_tdata[3:0];
         alu_ff  <= req_tdata[7:4];
         mb_ff   <= req_tdata[11:8];
         rd_ff   <= req_tdata[15:12];
         rn_ff   <= req_tdata[19:16];
         rs_ff   <= req_tdata[23:20];
         rm_ff   <= req_tdata[27:24];
         st_ff   <= req_tdata[29:28];
         sc_ff   <= req_tdata[34:30];
         imm_ff  <= req_tdata[66:35];
      end
      if (state_ff == S_RD2) begin
         a_val_ff <= rf_data_a;
         m_val_ff <= rf_data_b;
      end
      if (state_ff == S_EXEC) begin
         if (op_ff == asx_pkg::OP_DP && mb_ff[asx_pkg::MB_IMM]) begin
            op2_ff <= sh_imm[31:0];
            shc_ff <= sh_imm[32];
         end else begin
            op2_ff <= sh_reg[31:0];
            shc_ff <= sh_reg[32];
         end
         off_ff  <= mb_ff[asx_pkg::MB_UP] ? off_raw : 32'd0 - off_raw;
         prod_ff <= 32'(m_val_ff * rf_data_a);
         data_ff <= rf_data_b;
      end
      if (state_ff == S_ALU) begin
         addr_ff       <= ls_addr;
         in_mem_ff     <= in_mem;
         in_win_ff     <= in_win;
         pend_flush_ff <= 1'b0;
         pend_status_ff <= asx_pkg::STAT_DONE;
         pend_res_ff   <= '0;
         if (!cond_legal) begin
            pend_status_ff <= asx_pkg::STAT_ILLEGAL;
         end else if (!cond_ok) begin
            pend_status_ff <= asx_pkg::STAT_SKIP;
         end else begin
            case (op_ff)
               asx_pkg::OP_DP: begin
                  if (dp_legal) pend_res_ff    <= dp_res;
                  else          pend_status_ff <= asx_pkg::STAT_ILLEGAL;
               end
               asx_pkg::OP_MUL: pend_res_ff <= mul_res;
               asx_pkg::OP_LS: begin
                  pend_res_ff <= data_ff;
                  if (!mb_ff[asx_pkg::MB_LOAD] && !in_mem && !in_win) begin
                     pend_status_ff <= asx_pkg::STAT_BOUNDS;
                  end
               end
               default: begin
                  pend_res_ff   <= br_res;
                  pend_flush_ff <= 1'b1;
               end
            endcase
         end
      end
      if (state_ff == S_MEM) begin
         pend_res_ff    <= load_val;
         pend_status_ff <= (in_mem_ff || in_win_ff) ? asx_pkg::STAT_DONE
                                                    : asx_pkg::STAT_BOUNDS;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0, rsp_result_ff, rsp_flags_ff};
   assign rsp_tuser  = {rsp_flush_ff, rsp_status_ff};

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the hand-off state");

   a_flags_only_alu: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ALU && !reset) |=> $stable(flags_ff))
      else $error("flags changed outside the alu step");

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> (!rf_wr.en && !mem_req.we && state_ff == S_IDLE))
      else $error("activity while memory clear in progress");

endmodule

>>> tb/tb_arm_subset_execute_stage.sv
`timescale 1ns / 100ps

module tb_arm_subset_execute_stage;
   import asx_pkg::*;

   localparam int MEM_SIZE = 65536;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_PER_PHASE = 200;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  cond;
      logic [3:0]  alu;
      logic [3:0]  mb;
      logic [3:0]  rd;
      logic [3:0]  rn;
      logic [3:0]  rs;
      logic [3:0]  rm;
      logic [1:0]  st;
      logic [4:0]  sc;
      logic [31:0] imm;
   } instr_t;

   typedef struct packed {
      logic [1:0]  status;
      logic        flush;
      logic [3:0]  flags;
      logic [31:0] value;
   } outcome_t;

   typedef struct packed {
      instr_t   ins;
      logic     fixed;
      outcome_t want;
   } vector_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [31:0] csr_wdata;

   arm_subset_execute_stage #(.MEM_BYTES(MEM_SIZE)) dut (.*);

   // architectural copy of the block
   logic [31:0] arch_regs [16];
   logic [3:0]  arch_flags;
   logic [7:0]  data_mem [MEM_SIZE];
   logic [31:0] win_base;
   logic [31:0] win_limit;

   outcome_t pending_results[$];
   vector_t  directed_rows[$];
   int       mismatches;
   int       cycle_count;
   int       burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] shift_operand(input logic [1:0] kind,
                                                 input logic [31:0] amt_in,
                                                 input logic [31:0] v,
                                                 output logic carry);
      logic [31:0] amt;
      logic [31:0] res;
      amt = amt_in;
      carry = 1'b0;
      res = v;
      if (kind == SH_ROR) amt = amt & 32'd31;
      if (amt != 0) begin
         case (kind)
            SH_LSL: begin
               if (amt < 32) begin
                  carry = v[32 - amt];
                  res = v << amt;
               end else begin
                  if (amt == 32) carry = v[0];
                  res = '0;
               end
            end
            SH_LSR: begin
               if (amt < 32) begin
                  carry = v[amt - 1];
                  res = v >> amt;
               end else begin
                  if (amt == 32) carry = v[31];
                  res = '0;
               end
            end
            SH_ASR: begin
               if (amt < 32) begin
                  carry = v[amt - 1];
                  res = $signed(v) >>> amt;
               end else begin
                  carry = v[31];
                  res = {32{v[31]}};
               end
            end
            default: begin
               carry = v[amt - 1];
               res = (v >> amt) | (v << (32 - amt));
            end
         endcase
      end
      return res;
   endfunction

   // runs one instruction on the architectural copy
   function automatic outcome_t execute_instr(input instr_t i);
      outcome_t o;
      logic ok, legal, logical, write, shc, fc, in_mem, in_win;
      logic [31:0] amt, op2, a, off, addr, data;
      logic z, nv;
      o = '0;
      z = arch_flags[FL_Z];
      nv = arch_flags[FL_N] == arch_flags[FL_V];
      legal = 1'b1;
      ok = 1'b0;
      case (i.cond)
         COND_EQ: ok = z;
         COND_NE: ok = !z;
         COND_GE: ok = nv;
         COND_LT: ok = !nv;
         COND_GT: ok = !z && nv;
         COND_LE: ok = z || !nv;
         COND_AL: ok = 1'b1;
         default: legal = 1'b0;
      endcase
      amt = (i.rs == 0) ? {27'd0, i.sc} : arch_regs[i.rs];
      if (!legal) begin
         o.status = STAT_ILLEGAL;
      end else if (!ok) begin
         o.status = STAT_SKIP;
      end else if (i.op == OP_DP) begin
         a = arch_regs[i.rn];
         if (i.mb[MB_IMM]) op2 = shift_operand(i.st, {27'd0, i.sc}, i.imm, shc);
         else op2 = shift_operand(i.st, amt, arch_regs[i.rm], shc);
         fc = 1'b0;
         logical = 1'b0;
         write = 1'b1;
         case (i.alu)
            ALU_AND, ALU_TST: begin
               o.value = a & op2; logical = 1'b1; write = i.alu == ALU_AND;
            end
            ALU_EOR, ALU_TEQ: begin
               o.value = a ^ op2; logical = 1'b1; write = i.alu == ALU_EOR;
            end
            ALU_SUB, ALU_CMP: begin
               o.value = a - op2; fc = a >= op2; write = i.alu == ALU_SUB;
            end
            ALU_RSB: begin
               o.value = op2 - a; fc = op2 >= a;
            end
            ALU_ADD: begin
               o.value = a + op2; fc = o.value < a;
            end
            ALU_ORR: begin
               o.value = a | op2; logical = 1'b1;
            end
            ALU_MOV: begin
               o.value = op2; logical = 1'b1;
            end
            default: legal = 1'b0;
         endcase
         if (!legal) begin
            o.status = STAT_ILLEGAL;
            o.value = '0;
         end else begin
            if (logical) fc = shc;
            if (write) arch_regs[i.rd] = o.value;
            if (i.mb[MB_LOAD])
               arch_flags = {o.value[31], o.value == 0, fc, arch_flags[FL_V]};
         end
      end else if (i.op == OP_MUL) begin
         o.value = arch_regs[i.rm] * arch_regs[i.rs];
         if (i.mb[MB_UP]) o.value = o.value + arch_regs[i.rn];
         arch_regs[i.rd] = o.value;
         if (i.mb[MB_LOAD])
            arch_flags = {o.value[31], o.value == 0, arch_flags[FL_C], arch_flags[FL_V]};
      end else if (i.op == OP_LS) begin
         if (i.mb[MB_IMM]) off = shift_operand(i.st, amt, arch_regs[i.rm], shc);
         else off = i.imm;
         if (!i.mb[MB_UP]) off = -off;
         data = arch_regs[i.rd];
         if (i.mb[MB_PRE]) begin
            addr = arch_regs[i.rn] + off;
         end else begin
            addr = arch_regs[i.rn];
            arch_regs[i.rn] = addr + off;
         end
         in_mem = ({32'd0, addr} + 64'd4) <= MEM_SIZE;
         in_win = addr >= win_base && addr < win_limit;
         if (i.mb[MB_LOAD]) begin
            if (in_mem) begin
               o.value = {data_mem[addr + 3], data_mem[addr + 2],
                          data_mem[addr + 1], data_mem[addr]};
            end else if (in_win) begin
               o.value = addr;
            end else begin
               o.status = STAT_BOUNDS;
            end
            arch_regs[i.rd] = o.value;
         end else begin
            o.value = data;
            if (in_mem) begin
               data_mem[addr]     = data[7:0];
               data_mem[addr + 1] = data[15:8];
               data_mem[addr + 2] = data[23:16];
               data_mem[addr + 3] = data[31:24];
            end else if (!in_win) begin
               o.status = STAT_BOUNDS;
            end
         end
      end else begin
         o.value = arch_regs[PC_INDEX] + i.imm;
         arch_regs[PC_INDEX] = o.value;
         o.flush = 1'b1;
      end
      o.flags = arch_flags;
      return o;
   endfunction

   function automatic instr_t mk(input logic [1:0] op, input logic [3:0] cond,
                                 input logic [3:0] alu, input logic [3:0] mb,
                                 input logic [3:0] rd, input logic [3:0] rn,
                                 input logic [3:0] rs, input logic [3:0] rm,
                                 input logic [1:0] st, input logic [4:0] sc,
                                 input logic [31:0] imm);
      instr_t i;
      i = '{op, cond, alu, mb, rd, rn, rs, rm, st, sc, imm};
      return i;
   endfunction

   function automatic logic [3:0] pick_cond();
      logic [3:0] legal_conds [7];
      int k;
      legal_conds = '{COND_EQ, COND_NE, COND_GE, COND_LT, COND_GT, COND_LE, COND_AL};
      k = $urandom_range(0, 99);
      if (k < 78) return COND_AL;
      if (k < 95) return legal_conds[$urandom_range(0, 6)];
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [31:0] pick_address();
      case ($urandom_range(0, 5))
         0, 1, 2: return $urandom_range(0, MEM_SIZE - 1);
         3: return win_base + $urandom_range(0, 79) - 8;
         4: return MEM_SIZE - $urandom_range(0, 8);
         default: return $urandom;
      endcase
   endfunction

   function automatic instr_t random_instr();
      logic [3:0] alu_codes [10];
      instr_t i;
      int k;
      alu_codes = '{ALU_AND, ALU_EOR, ALU_SUB, ALU_RSB, ALU_ADD,
                    ALU_TST, ALU_TEQ, ALU_CMP, ALU_ORR, ALU_MOV};
      i = instr_t'({$urandom, $urandom, $urandom});
      i.cond = pick_cond();
      k = $urandom_range(0, 99);
      if (k < 22) begin
         // load an address or a value into a register
         i.op = OP_DP;
         i.alu = ALU_MOV;
         i.mb = {1'($urandom_range(0, 1)), 3'b001};
         i.sc = 0;
         i.rd = $urandom_range(1, 14);
         i.imm = pick_address();
      end else if (k < 52) begin
         i.op = OP_DP;
         if ($urandom_range(0, 9) != 0) i.alu = alu_codes[$urandom_range(0, 9)];
         if ($urandom_range(0, 3) != 0) i.rs = 0;
      end else if (k < 62) begin
         i.op = OP_MUL;
      end else if (k < 90) begin
         i.op = OP_LS;
         i.rn = $urandom_range(1, 14);
         if ($urandom_range(0, 9) != 0) begin
            i.mb[MB_IMM] = 1'b0;
            i.imm = $urandom_range(0, 64);
         end else if ($urandom_range(0, 1) == 0) begin
            i.rs = 0;
            i.sc = $urandom_range(0, 3);
         end
      end else begin
         i.op = OP_BR;
      end
      return i;
   endfunction

   task automatic wait_idle();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_GPIO_BASE) win_base = value;
      else win_limit = value;
   endtask

   task automatic issue(input instr_t i, input logic fixed, input outcome_t want);
      outcome_t o;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser <= i.op;
      req_tdata <= {5'd0, i.imm, i.sc, i.st, i.rm, i.rs, i.rn, i.rd, i.mb, i.alu, i.cond};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      o = execute_instr(i);
      pending_results.push_back(fixed ? want : o);
      burst_left--;
   endtask

   // receiver alternates between always ready and random stalls
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if ((cycle_count / 700) % 3 == 0) rsp_tready <= 1'b1;
      else rsp_tready <= $urandom_range(0, 2) != 0;
   end

   always @(posedge clock) begin
      outcome_t exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no instruction outstanding");
            mismatches++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tuser[1:0] !== exp_r.status) begin
               $error("status: expected %0d, got %0d", exp_r.status, rsp_tuser[1:0]);
               mismatches++;
            end
            if (rsp_tuser[2] !== exp_r.flush) begin
               $error("flush: expected %0d, got %0d", exp_r.flush, rsp_tuser[2]);
               mismatches++;
            end
            if (rsp_tdata[3:0] !== exp_r.flags) begin
               $error("flags_out: expected %h, got %h", exp_r.flags, rsp_tdata[3:0]);
               mismatches++;
            end
            if (rsp_tdata[35:4] !== exp_r.value) begin
               $error("result_value: expected %h, got %h", exp_r.value, rsp_tdata[35:4]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      logic [31:0] window_settings [4][2];
      instr_t i;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_tready = 1'b0;
      mismatches = 0;
      cycle_count = 0;
      burst_left = 0;
      arch_flags = '0;
      win_base = GPIO_BASE_RESET;
      win_limit = GPIO_LIMIT_RESET;
      foreach (arch_regs[r]) arch_regs[r] = '0;
      foreach (data_mem[b]) data_mem[b] = '0;
      window_settings = '{'{GPIO_BASE_RESET, GPIO_LIMIT_RESET},
                          '{32'h0001_0000, 32'h0001_0040},
                          '{32'h0000_0000, 32'hFFFF_FFFF},
                          '{32'hFFFF_FFFF, 32'h0000_0000}};

      // directed table: typed expectations only for the obvious rows
      directed_rows.push_back('{mk(OP_DP, COND_EQ, ALU_MOV, 4'b1001, 1, 0, 0, 0, 0, 0, 5),
                                1'b1, '{STAT_SKIP, 1'b0, 4'b0000, 32'd0}});
      directed_rows.push_back('{mk(OP_DP, 4'd15, ALU_MOV, 4'b1001, 1, 0, 0, 0, 0, 0, 5),
                                1'b1, '{STAT_ILLEGAL, 1'b0, 4'b0000, 32'd0}});
      directed_rows.push_back('{mk(OP_DP, COND_AL, 4'd5, 4'b1001, 1, 0, 0, 0, 0, 0, 5),
                                1'b1, '{STAT_ILLEGAL, 1'b0, 4'b0000, 32'd0}});
      directed_rows.push_back('{mk(OP_DP, COND_AL, ALU_MOV, 4'b1001, 1, 0, 0, 0, 0, 0,
                                   32'hFFFF_FFFF),
                                1'b1, '{STAT_DONE, 1'b0, 4'b1000, 32'hFFFF_FFFF}});
      directed_rows.push_back('{mk(OP_DP, COND_AL, ALU_ADD, 4'b1001, 2, 1, 0, 0, 0, 0, 1),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_EQ, ALU_MOV, 4'b0001, 3, 0, 0, 0, 0, 0, 32),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_AL, ALU_MOV, 4'b1001, 7, 0, 0, 0, SH_ROR, 31,
                                   32'h8000_0000), 1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_AL, ALU_SUB, 4'b1000, 4, 1, 3, 1, SH_LSL, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_AL, ALU_RSB, 4'b1000, 4, 1, 3, 1, SH_LSR, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_AL, ALU_CMP, 4'b1000, 4, 7, 3, 1, SH_ASR, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_GE, ALU_TST, 4'b1000, 4, 1, 3, 1, SH_ROR, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_LT, ALU_TEQ, 4'b1000, 4, 1, 0, 1, SH_LSR, 4, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_AL, ALU_EOR, 4'b0000, 5, 1, 0, 7, SH_LSL, 31, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_GT, ALU_AND, 4'b1001, 5, 1, 0, 0, 0, 0,
                                   32'h0F0F_0F0F), 1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_LE, ALU_ORR, 4'b1001, 6, 1, 0, 0, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_MUL, COND_AL, 0, 4'b1000, 8, 0, 1, 1, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_MUL, COND_NE, 0, 4'b1100, 8, 1, 3, 2, 0, 0, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_AL, ALU_MOV, 4'b0001, 9, 0, 0, 0, 0, 0,
                                   32'h0000_1000), 1'b0, '0});
      directed_rows.push_back('{mk(OP_LS, COND_AL, 0, 4'b0110, 1, 9, 0, 0, 0, 0, 4),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_LS, COND_AL, 0, 4'b1100, 10, 9, 0, 0, 0, 0, 4),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_LS, COND_AL, 0, 4'b1010, 11, 0, 0, 0, 0, 0,
                                   MEM_SIZE - 4), 1'b0, '0});
      directed_rows.push_back('{mk(OP_LS, COND_AL, 0, 4'b1010, 11, 0, 0, 0, 0, 0,
                                   MEM_SIZE - 3), 1'b0, '0});
      directed_rows.push_back('{mk(OP_DP, COND_AL, ALU_MOV, 4'b0001, 12, 0, 0, 0, 0, 0,
                                   GPIO_BASE_RESET), 1'b0, '0});
      directed_rows.push_back('{mk(OP_LS, COND_AL, 0, 4'b1010, 13, 12, 0, 0, 0, 0, 8),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_LS, COND_AL, 0, 4'b0000, 1, 12, 0, 0, 0, 0, 4),
                                1'b0, '0});
      directed_rows.push_back('{mk(OP_BR, COND_AL, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFC),
                                1'b0, '0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         issue(directed_rows[n].ins, directed_rows[n].fixed, directed_rows[n].want);

      for (int phase = 0; phase < 4; phase++) begin
         // hold new instructions until the pipe has drained before touching the window
         req_tvalid <= 1'b0;
         burst_left = 0;
         wait_idle();
         write_csr(CSR_GPIO_BASE, window_settings[phase][0]);
         write_csr(CSR_GPIO_LIMIT, window_settings[phase][1]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            i = random_instr();
            issue(i, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
      wait_idle();

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/asx_pkg.sv
rtl/asx_regfile.sv
rtl/asx_mem.sv
rtl/arm_subset_execute_stage.sv
tb/tb_arm_subset_execute_stage.sv
